FILE: design/amaf_pkg.sv
// Shared types, constants and character helpers for the millivolt ASCII formatter.
package amaf_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int SAMPLE_W    = 12;
  localparam int REF_W       = 14;
  localparam int PROD_W      = SAMPLE_BITS + REF_W;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [REF_W-1:0] REF_RESET = 14'd4600;
  localparam logic [REF_W-1:0] MV_MAX    = 14'd9999;

  // Reciprocal constants for the digit split; exact over the value ranges used.
  localparam int RECIP_THOU       = 8389;  // 2^23 / 1000, rounded up
  localparam int RECIP_THOU_SHIFT = 23;
  localparam int RECIP_HUND       = 41;    // 2^12 / 100, rounded up
  localparam int RECIP_HUND_SHIFT = 12;
  localparam int RECIP_TENS       = 205;   // 2^11 / 10, rounded up
  localparam int RECIP_TENS_SHIFT = 11;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_C     = 8'h63;
  localparam logic [7:0] ASCII_H     = 8'h68;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_EQ    = 8'h3D;
  localparam logic [7:0] ASCII_DOT   = 8'h2E;
  localparam logic [7:0] ASCII_CR    = 8'h0D;

  // Character positions within one line.
  localparam logic [3:0] POS_C    = 4'd0;
  localparam logic [3:0] POS_H    = 4'd1;
  localparam logic [3:0] POS_CHAN = 4'd2;
  localparam logic [3:0] POS_SP1  = 4'd3;
  localparam logic [3:0] POS_EQ   = 4'd4;
  localparam logic [3:0] POS_SP2  = 4'd5;
  localparam logic [3:0] POS_THOU = 4'd6;
  localparam logic [3:0] POS_DOT  = 4'd7;
  localparam logic [3:0] POS_HUND = 4'd8;
  localparam logic [3:0] POS_TENS = 4'd9;
  localparam logic [3:0] POS_ONES = 4'd10;
  localparam logic [3:0] POS_CR   = 4'd11;

  typedef struct packed {
    logic [SAMPLE_W-1:0] adc_sample;
    logic                channel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_item_t;

  // Classified line: channel and four decimal digits.
  typedef struct packed {
    logic       channel;
    logic [3:0] d_thou;
    logic [3:0] d_hund;
    logic [3:0] d_tens;
    logic [3:0] d_ones;
  } line_rec_t;

  typedef struct packed {
    logic      valid;
    line_rec_t rec;
  } line_push_t;

  typedef struct packed {
    logic      empty;
    line_rec_t rec;
  } line_head_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    digit_char = ASCII_ZERO + {4'd0, d};
  endfunction

  function automatic logic [7:0] line_char(input line_rec_t rec, input logic [3:0] pos);
    case (pos)
      POS_C:    line_char = ASCII_C;
      POS_H:    line_char = ASCII_H;
      POS_CHAN: line_char = ASCII_ZERO + {7'd0, rec.channel};
      POS_SP1:  line_char = ASCII_SPACE;
      POS_EQ:   line_char = ASCII_EQ;
      POS_SP2:  line_char = ASCII_SPACE;
      POS_THOU: line_char = digit_char(rec.d_thou);
      POS_DOT:  line_char = ASCII_DOT;
      POS_HUND: line_char = digit_char(rec.d_hund);
      POS_TENS: line_char = digit_char(rec.d_tens);
      POS_ONES: line_char = digit_char(rec.d_ones);
      POS_CR:   line_char = ASCII_CR;
      default:  line_char = ASCII_CR;
    endcase
  endfunction

endpackage

FILE: design/adc_millivolt_ascii_formatter.sv
// Top level of the ADC millivolt ASCII line formatter.
//
//   channel  direction  handshake            payload
//   -------  ---------  -------------------  --------------------------------
//   input    in         push / full          item   : in_item_t (sample, channel)
//   result   out        empty / pop          result : out_item_t (character, last)
//   config   in         cfg_we               cfg_data : reference in millivolts
//
// Each sample yields twelve characters, one per cycle while pop is held; the character
// sequencer sets the sustained sample rate.
// After the sample transfer, the first character passes through the five-stage scaling
// and digit pipeline, the queue and the output register.
// Up to four lines may be pending; full rises when four are in flight.
// Reset restores the reference to 4600 mV and empties all stages.
module adc_millivolt_ascii_formatter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  amaf_pkg::in_item_t          item,
  output logic                        empty,
  input  logic                        pop,
  output amaf_pkg::out_item_t         result,
  input  logic                        cfg_we,
  input  logic [amaf_pkg::REF_W-1:0]  cfg_data
);

  amaf_pkg::line_push_t  line_push;
  amaf_pkg::line_head_t  line_head;
  logic                  line_done;

  amaf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .release_slot (line_done),
    .line_out     (line_push)
  );

  amaf_line_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (line_push),
    .rd   (line_done),
    .head (line_head)
  );

  amaf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (line_head),
    .line_done (line_done),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

FILE: design/amaf_front.sv
// Front end: accepts samples, scales to millivolts and splits into decimal digits.
module amaf_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  amaf_pkg::in_item_t           item,
  input  logic                         cfg_we,
  input  logic [amaf_pkg::REF_W-1:0]   cfg_data,
  input  logic                         release_slot,
  output amaf_pkg::line_push_t         line_out
);

  logic                          accept;
  logic [amaf_pkg::REF_W-1:0]    reference_mv;
  logic [amaf_pkg::QCNT_W-1:0]   inflight;
  logic [4:0]                    vld;

  logic [15:0]                   sample_ext;
  logic [amaf_pkg::PROD_W-1:0]   prod1;
  logic                          chan1, chan2, chan3, chan4;
  amaf_pkg::line_rec_t           rec5;

  logic [amaf_pkg::REF_W-1:0]    mv_raw, mv_sat;
  logic [26:0]                   thou_prod;
  logic [amaf_pkg::REF_W-1:0]    mv2;
  logic [3:0]                    th2, th3, th4;

  logic [amaf_pkg::REF_W-1:0]    rem_thou;
  logic [9:0]                    r3;

  logic [15:0]                   hund_prod;
  logic [3:0]                    h_calc, h4;
  logic [9:0]                    rem_hund;
  logic [6:0]                    r4;

  logic [14:0]                   tens_prod;
  logic [3:0]                    t_calc;
  logic [6:0]                    rem_tens;

  assign accept = push && !full;
  assign full   = (inflight == amaf_pkg::QCNT_W'(amaf_pkg::QDEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_mv <= amaf_pkg::REF_RESET;
    end else if (cfg_we) begin
      reference_mv <= cfg_data;
    end
  end

  // Count lines in the pipe and the queue; a slot frees when the back end drains a line.
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (accept && !release_slot) begin
      inflight <= inflight + 1'b1;
    end else if (!accept && release_slot) begin
      inflight <= inflight - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], accept};
    end
  end

  assign sample_ext = {{(16-amaf_pkg::SAMPLE_W){1'b0}}, item.adc_sample};

  // Stage 1: scale
  always_ff @(posedge clk) begin
    prod1 <= amaf_pkg::PROD_W'(sample_ext[amaf_pkg::SAMPLE_BITS-1:0])
           * amaf_pkg::PROD_W'(reference_mv);
    chan1 <= item.channel;
  end

  // Stage 2: saturate, thousands digit
  assign mv_raw    = prod1[amaf_pkg::PROD_W-1:amaf_pkg::SAMPLE_BITS];
  assign mv_sat    = (mv_raw > amaf_pkg::MV_MAX) ? amaf_pkg::MV_MAX : mv_raw;
  assign thou_prod = 27'(mv_sat) * 27'(amaf_pkg::RECIP_THOU);

  always_ff @(posedge clk) begin
    mv2   <= mv_sat;
    th2   <= thou_prod[amaf_pkg::RECIP_THOU_SHIFT +: 4];
    chan2 <= chan1;
  end

  // Stage 3: remainder below one thousand
  assign rem_thou = mv2 - 14'(th2 * 14'd1000);

  always_ff @(posedge clk) begin
    r3    <= rem_thou[9:0];
    th3   <= th2;
    chan3 <= chan2;
  end

  // Stage 4: hundreds digit and remainder below one hundred
  assign hund_prod = 16'(r3) * 16'(amaf_pkg::RECIP_HUND);
  assign h_calc    = hund_prod[amaf_pkg::RECIP_HUND_SHIFT +: 4];
  assign rem_hund  = r3 - 10'(h_calc * 10'd100);

  always_ff @(posedge clk) begin
    r4    <= rem_hund[6:0];
    h4    <= h_calc;
    th4   <= th3;
    chan4 <= chan3;
  end

  // Stage 5: tens and ones digits
  assign tens_prod = 15'(r4) * 15'(amaf_pkg::RECIP_TENS);
  assign t_calc    = tens_prod[amaf_pkg::RECIP_TENS_SHIFT +: 4];
  assign rem_tens  = r4 - 7'(t_calc * 7'd10);

  always_ff @(posedge clk) begin
    rec5.channel <= chan4;
    rec5.d_thou  <= th4;
    rec5.d_hund  <= h4;
    rec5.d_tens  <= t_calc;
    rec5.d_ones  <= rem_tens[3:0];
  end

  assign line_out.valid = vld[4];
  assign line_out.rec   = rec5;

endmodule

FILE: design/amaf_line_queue.sv
// Short queue of classified lines between the front and back ends.
module amaf_line_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  amaf_pkg::line_push_t  wr,
  input  logic                  rd,
  output amaf_pkg::line_head_t  head
);

  amaf_pkg::line_rec_t           mem [amaf_pkg::QDEPTH];
  logic [amaf_pkg::QPTR_W-1:0]   wr_ptr;
  logic [amaf_pkg::QPTR_W-1:0]   rd_ptr;
  logic [amaf_pkg::QCNT_W-1:0]   count;
  logic                          do_rd;

  assign do_rd = rd && (count != '0);

  always_ff @(posedge clk) begin
    if (wr.valid) begin
      mem[wr_ptr] <= wr.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr.valid && !do_rd) begin
        count <= count + 1'b1;
      end else if (!wr.valid && do_rd) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head.empty = (count == '0);
  assign head.rec   = mem[rd_ptr];

endmodule

FILE: design/amaf_back.sv
// Back end: walks one queued line character by character into the output register.
module amaf_back (
  input  logic                  clk,
  input  logic                  rst,
  input  amaf_pkg::line_head_t  head,
  output logic                  line_done,
  output logic                  empty,
  input  logic                  pop,
  output amaf_pkg::out_item_t   result
);

  logic        out_valid;
  logic [3:0]  pos;
  logic        load;
  logic        at_end;

  assign load      = !head.empty && (!out_valid || pop);
  assign at_end    = (pos == amaf_pkg::POS_CR);
  assign line_done = load && at_end;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= amaf_pkg::POS_C;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        pos       <= at_end ? amaf_pkg::POS_C : pos + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the character until it is popped.
  always_ff @(posedge clk) begin
    if (load) begin
      result.character <= amaf_pkg::line_char(head.rec, pos);
      result.last      <= at_end;
    end
  end

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the ADC millivolt ASCII line formatter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import amaf_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int REPORT_MAX   = 10;
  localparam int LINE_CHARS   = 12;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             push     = 1'b0;
  logic             full;
  in_item_t         item     = '0;
  logic             empty;
  logic             pop      = 1'b0;
  out_item_t        result;
  logic             cfg_we   = 1'b0;
  logic [REF_W-1:0] cfg_data = '0;

  // Local copy of the reference register and the characters still owed.
  logic [REF_W-1:0] scale_mv = REF_RESET;
  out_item_t        line_char_q[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  bit rx_stall_on    = 1'b0;
  int rx_stall_left  = 0;
  bit tx_bursty      = 1'b0;
  int tx_burst_left  = 0;

  always #1 clk = ~clk;

  adc_millivolt_ascii_formatter i_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Build the expected line "chN = V.mmm" + CR for one accepted sample.
  function automatic void predict_line(input in_item_t smp);
    int unsigned mv;
    logic [7:0]  line_text [LINE_CHARS];
    out_item_t   ch;
    mv = (int'(smp.adc_sample) * int'(scale_mv)) >> SAMPLE_BITS;
    if (mv > MV_MAX) mv = MV_MAX;
    line_text[0]  = ASCII_C;
    line_text[1]  = ASCII_H;
    line_text[2]  = ASCII_ZERO + {7'd0, smp.channel};
    line_text[3]  = ASCII_SPACE;
    line_text[4]  = ASCII_EQ;
    line_text[5]  = ASCII_SPACE;
    line_text[6]  = ASCII_ZERO + 8'((mv / 1000) % 10);
    line_text[7]  = ASCII_DOT;
    line_text[8]  = ASCII_ZERO + 8'((mv / 100) % 10);
    line_text[9]  = ASCII_ZERO + 8'((mv / 10) % 10);
    line_text[10] = ASCII_ZERO + 8'(mv % 10);
    line_text[11] = ASCII_CR;
    for (int k = 0; k < LINE_CHARS; k++) begin
      ch.character = line_text[k];
      ch.last      = (k == LINE_CHARS - 1);
      line_char_q.push_back(ch);
    end
  endfunction

  // Compare every character transfer with the oldest expected one.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (line_char_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected char: got 0x%02h last=%0b", result.character, result.last);
      end else begin
        want = line_char_q.pop_front();
        if (result.character !== want.character || result.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("char mismatch: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                     want.character, want.last, result.character, result.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d chars pending", cycle_count, line_char_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: hold pop low for random stretches when stalls are enabled.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (rx_stall_left > 0) begin
      pop           <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if (rx_stall_on && $urandom_range(0, 4) == 0) begin
      pop           <= 1'b0;
      rx_stall_left <= $urandom_range(0, 7);
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic chan);
    if (tx_bursty) begin
      if (tx_burst_left == 0) begin
        @(negedge clk) push = 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
        tx_burst_left = $urandom_range(1, 10);
      end
      tx_burst_left--;
    end
    @(negedge clk);
    push            = 1'b1;
    item.adc_sample = sample;
    item.channel    = chan;
    // Hold the item until the transfer happens.
    do @(posedge clk); while (full);
    predict_line(item);
  endtask

  task automatic wait_drained();
    @(negedge clk) push = 1'b0;
    while (line_char_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_reference(input logic [REF_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_we   = 1'b0;
    scale_mv = value;
  endtask

  task automatic test_directed_lines();
    tx_bursty   = 1'b0;
    rx_stall_on = 1'b0;
    send_sample(12'd0, 1'b0);
    send_sample(12'd4095, 1'b1);
    send_sample(12'd1, 1'b0);
    send_sample(12'd2048, 1'b1);
    send_sample(12'd4094, 1'b0);
    // Straddle the one-volt boundary at the reset reference.
    send_sample(12'd890, 1'b1);
    send_sample(12'd891, 1'b0);
    send_sample(12'hAAA, 1'b1);
  endtask

  task automatic test_reference_extremes();
    set_reference(14'd0);
    send_sample(12'd4095, 1'b1);
    send_sample(12'h555, 1'b0);
    set_reference(14'd9999);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd2048, 1'b1);
    // Reference above range: scaled value saturates at 9.999.
    set_reference(14'h3FFF);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd2501, 1'b1);
    send_sample(12'd2500, 1'b0);
    send_sample(12'd1, 1'b1);
    set_reference(14'd1);
    send_sample(12'd4095, 1'b1);
    set_reference(REF_RESET);
    send_sample(12'd4095, 1'b0);
  endtask

  task automatic test_random_lines(input int count, input logic [REF_W-1:0] ref_value,
                                   input bit bursty, input bit stalls);
    logic [SAMPLE_W-1:0] sample;
    set_reference(ref_value);
    tx_bursty   = bursty;
    rx_stall_on = stalls;
    repeat (count) begin
      if ($urandom_range(0, 15) == 0)
        sample = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
      else
        sample = SAMPLE_W'($urandom_range(0, 4095));
      send_sample(sample, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_pause_for_drain();
    tx_bursty   = 1'b1;
    rx_stall_on = 1'b1;
    repeat (3) begin
      repeat (6) send_sample(SAMPLE_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
      wait_drained();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    test_directed_lines();
    test_reference_extremes();
    test_random_lines(48, REF_W'($urandom_range(0, 9999)), 1'b1, 1'b1);
    test_random_lines(48, 14'd9999, 1'b1, 1'b1);
    test_random_lines(48, REF_W'($urandom_range(10000, 16383)), 1'b1, 1'b1);
    test_random_lines(48, REF_RESET, 1'b0, 1'b0);
    test_random_lines(48, REF_W'($urandom_range(1, 9999)), 1'b1, 1'b0);
    test_random_lines(48, 14'h3FFF, 1'b0, 1'b1);
    test_random_lines(48, REF_W'($urandom_range(0, 16383)), 1'b1, 1'b1);
    test_pause_for_drain();

    wait_drained();
    if (mismatch_count == 0 && line_char_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
